// ----- rtl/controller_report_mapper_unit_macros.svh -----
// Assertion macros used by the controller report mapper queue
`ifndef CONTROLLER_REPORT_MAPPER_UNIT_MACROS_SVH
`define CONTROLLER_REPORT_MAPPER_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crm_pkg.sv -----
// Shared types, codes and scaling functions for the controller report mapper
package crm_pkg;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_NUNCHUK = 2'd1,
        MODE_CLASSIC = 2'd2,
        MODE_DRUM    = 2'd3
    } ext_mode_t;

    localparam logic [1:0] REG_EXT_MODE = 2'd0;
    localparam logic [1:0] REG_NUN_DZ   = 2'd1;
    localparam logic [1:0] REG_CL_DZ    = 2'd2;

    localparam logic [6:0] NUN_DZ_RESET = 7'd5;
    localparam logic [6:0] CL_DZ_RESET  = 7'd3;

    localparam logic [7:0] NUN_MIN     = 8'd35;
    localparam logic [7:0] NUN_MAX     = 8'd220;
    localparam logic [7:0] STICK_CTR   = 8'd128;
    localparam logic [7:0] STICK_FULL  = 8'd255;

    // console button bit positions
    localparam int BTN_PAD_LEFT  = 0;
    localparam int BTN_PAD_RIGHT = 1;
    localparam int BTN_PAD_DOWN  = 2;
    localparam int BTN_UP        = 3;
    localparam int BTN_START     = 4;
    localparam int BTN_SELECT    = 5;
    localparam int BTN_TRI       = 6;
    localparam int BTN_SQ        = 7;
    localparam int BTN_CIRC      = 8;
    localparam int BTN_CROSS     = 9;
    localparam int BTN_L1        = 10;
    localparam int BTN_R1        = 11;
    localparam int BTN_VOLDN     = 12;
    localparam int BTN_VOLUP     = 13;
    localparam int BTN_SYS_HOME  = 14;

    typedef struct packed {
        ext_mode_t   mode;
        logic [14:0] buttons;
        logic [7:0]  stick_a;
        logic [7:0]  stick_b;
        logic [7:0]  stick_c;
        logic [7:0]  stick_d;
    } queue_item_t;

    typedef struct packed {
        ext_mode_t mode;
        logic      clear;
    } front_ctl_t;

    // v*255/185 for v in 0..185: v + floor(14v/37), reciprocal 28340/2^20
    function automatic logic [7:0] scale_nunchuk(input logic [7:0] v);
        logic [11:0] t;
        logic [26:0] p;
        logic [6:0]  q;
        t = 12'(v) * 12'd14;
        p = 27'(t) * 27'd28340;
        q = p[26:20];
        return v + 8'(q);
    endfunction

    // x*255/63 = 4x + floor(x/21)
    function automatic logic [7:0] scale_six(input logic [5:0] x);
        logic [1:0] q;
        q = 2'(x >= 6'd21) + 2'(x >= 6'd42) + 2'(x >= 6'd63);
        return {x, 2'b00} + 8'(q);
    endfunction

    // x*255/31 = 8x + floor(7x/31)
    function automatic logic [7:0] scale_five(input logic [4:0] x);
        logic [7:0] t;
        logic [2:0] q;
        t = 8'(x) * 8'd7;
        q = 3'd0;
        for (int k = 1; k < 8; k++) begin
            q = q + 3'(t >= 8'(31 * k));
        end
        return {x, 3'b000} + 8'(q);
    endfunction

    function automatic logic beyond(input logic [7:0] v, input logic [6:0] dz);
        logic [7:0] d;
        d = (v >= STICK_CTR) ? (v - STICK_CTR) : (STICK_CTR - v);
        return d > {1'b0, dz};
    endfunction

endpackage

// ----- rtl/crm_front.sv -----
// Front end: accepts reports, updates held extension state, maps buttons
module crm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  crm_pkg::front_ctl_t ctl,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_has_extension,
    input  logic [15:0]         s_core_buttons,
    input  logic [7:0]          s_ext_byte_a,
    input  logic [7:0]          s_ext_byte_b,
    input  logic [7:0]          s_ext_byte_c,
    input  logic [7:0]          s_ext_byte_d,
    input  logic [7:0]          s_ext_byte_e,
    input  logic [7:0]          s_ext_byte_f,
    output logic                push,
    input  logic                push_ready,
    output crm_pkg::queue_item_t push_item
);

    logic [7:0]  nun_x_reg, nun_x_next;
    logic [7:0]  nun_y_reg, nun_y_next;
    logic [1:0]  nun_keys_reg, nun_keys_next;
    logic [5:0]  cl_lx_reg, cl_lx_next;
    logic [5:0]  cl_ly_reg, cl_ly_next;
    logic [4:0]  cl_rx_reg, cl_rx_next;
    logic [4:0]  cl_ry_reg, cl_ry_next;
    logic [15:0] cl_keys_reg, cl_keys_next;
    logic [7:0]  drum_reg, drum_next;
    logic        accept;
    logic [14:0] btn;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign push    = s_valid;

    always_comb begin
        nun_x_next    = nun_x_reg;
        nun_y_next    = nun_y_reg;
        nun_keys_next = nun_keys_reg;
        cl_lx_next    = cl_lx_reg;
        cl_ly_next    = cl_ly_reg;
        cl_rx_next    = cl_rx_reg;
        cl_ry_next    = cl_ry_reg;
        cl_keys_next  = cl_keys_reg;
        drum_next     = drum_reg;
        if (s_has_extension) begin
            case (ctl.mode)
                crm_pkg::MODE_NUNCHUK: begin
                    nun_x_next    = s_ext_byte_a;
                    nun_y_next    = s_ext_byte_b;
                    nun_keys_next = ~s_ext_byte_f[1:0];
                end
                crm_pkg::MODE_CLASSIC: begin
                    cl_lx_next   = s_ext_byte_a[5:0];
                    cl_ly_next   = s_ext_byte_b[5:0];
                    cl_rx_next   = {s_ext_byte_a[7:6], s_ext_byte_b[7:6], s_ext_byte_c[7]};
                    cl_ry_next   = s_ext_byte_c[4:0];
                    cl_keys_next = ~{s_ext_byte_f, s_ext_byte_e};
                end
                crm_pkg::MODE_DRUM: begin
                    drum_next = ~s_ext_byte_f;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        btn = '0;
        btn[crm_pkg::BTN_PAD_LEFT]  = s_core_buttons[0];
        btn[crm_pkg::BTN_PAD_RIGHT] = s_core_buttons[1];
        btn[crm_pkg::BTN_PAD_DOWN]  = s_core_buttons[2];
        btn[crm_pkg::BTN_UP]        = s_core_buttons[3];
        btn[crm_pkg::BTN_START]     = s_core_buttons[4];
        btn[crm_pkg::BTN_TRI]       = s_core_buttons[8];
        btn[crm_pkg::BTN_SQ]        = s_core_buttons[9];
        btn[crm_pkg::BTN_CIRC]      = s_core_buttons[10];
        btn[crm_pkg::BTN_CROSS]     = s_core_buttons[11];
        btn[crm_pkg::BTN_SELECT]    = s_core_buttons[12];
        btn[crm_pkg::BTN_SYS_HOME]  = s_core_buttons[15];
        push_item         = '0;
        push_item.mode    = ctl.mode;
        case (ctl.mode)
            crm_pkg::MODE_NUNCHUK: begin
                btn[crm_pkg::BTN_R1] = btn[crm_pkg::BTN_R1] | nun_keys_next[0];
                btn[crm_pkg::BTN_L1] = btn[crm_pkg::BTN_L1] | nun_keys_next[1];
                push_item.stick_a = nun_x_next;
                push_item.stick_b = nun_y_next;
            end
            crm_pkg::MODE_CLASSIC: begin
                btn[crm_pkg::BTN_CROSS]     = btn[crm_pkg::BTN_CROSS]     | cl_keys_next[12];
                btn[crm_pkg::BTN_CIRC]      = btn[crm_pkg::BTN_CIRC]      | cl_keys_next[14];
                btn[crm_pkg::BTN_TRI]       = btn[crm_pkg::BTN_TRI]       | cl_keys_next[11];
                btn[crm_pkg::BTN_SQ]        = btn[crm_pkg::BTN_SQ]        | cl_keys_next[13];
                btn[crm_pkg::BTN_PAD_LEFT]  = btn[crm_pkg::BTN_PAD_LEFT]  | cl_keys_next[9];
                btn[crm_pkg::BTN_PAD_RIGHT] = btn[crm_pkg::BTN_PAD_RIGHT] | cl_keys_next[7];
                btn[crm_pkg::BTN_PAD_DOWN]  = btn[crm_pkg::BTN_PAD_DOWN]  | cl_keys_next[6];
                btn[crm_pkg::BTN_UP]        = btn[crm_pkg::BTN_UP]        | cl_keys_next[8];
                btn[crm_pkg::BTN_R1]        = btn[crm_pkg::BTN_R1]        | cl_keys_next[1];
                btn[crm_pkg::BTN_L1]        = btn[crm_pkg::BTN_L1]        | cl_keys_next[5];
                btn[crm_pkg::BTN_START]     = btn[crm_pkg::BTN_START]     | cl_keys_next[2];
                btn[crm_pkg::BTN_SELECT]    = btn[crm_pkg::BTN_SELECT]    | cl_keys_next[4];
                btn[crm_pkg::BTN_VOLDN]     = btn[crm_pkg::BTN_VOLDN]     | cl_keys_next[15];
                btn[crm_pkg::BTN_VOLUP]     = btn[crm_pkg::BTN_VOLUP]     | cl_keys_next[10];
                btn[crm_pkg::BTN_SYS_HOME]  = btn[crm_pkg::BTN_SYS_HOME]  | cl_keys_next[3];
                push_item.stick_a = {2'b00, cl_lx_next};
                push_item.stick_b = {2'b00, cl_ly_next};
                push_item.stick_c = {3'b000, cl_rx_next};
                push_item.stick_d = {3'b000, cl_ry_next};
            end
            crm_pkg::MODE_DRUM: begin
                btn[crm_pkg::BTN_PAD_LEFT] = btn[crm_pkg::BTN_PAD_LEFT] | drum_next[6];
                btn[crm_pkg::BTN_L1]       = btn[crm_pkg::BTN_L1]       | drum_next[5];
                btn[crm_pkg::BTN_CIRC]     = btn[crm_pkg::BTN_CIRC]     | drum_next[4];
                btn[crm_pkg::BTN_R1]       = btn[crm_pkg::BTN_R1]       | drum_next[3];
            end
            default: begin
            end
        endcase
        push_item.buttons = btn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            nun_x_reg    <= crm_pkg::STICK_CTR;
            nun_y_reg    <= crm_pkg::STICK_CTR;
            nun_keys_reg <= '0;
            cl_lx_reg    <= 6'd32;
            cl_ly_reg    <= 6'd32;
            cl_rx_reg    <= 5'd16;
            cl_ry_reg    <= 5'd16;
            cl_keys_reg  <= '0;
            drum_reg     <= '0;
        end else if (accept) begin
            nun_x_reg    <= nun_x_next;
            nun_y_reg    <= nun_y_next;
            nun_keys_reg <= nun_keys_next;
            cl_lx_reg    <= cl_lx_next;
            cl_ly_reg    <= cl_ly_next;
            cl_rx_reg    <= cl_rx_next;
            cl_ry_reg    <= cl_ry_next;
            cl_keys_reg  <= cl_keys_next;
            drum_reg     <= drum_next;
        end
    end

endmodule

// ----- rtl/crm_fifo.sv -----
// Two-entry item queue between front and back ends
`include "controller_report_mapper_unit_macros.svh"

module crm_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    output logic                 push_ready,
    input  crm_pkg::queue_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output crm_pkg::queue_item_t pop_item
);

    crm_pkg::queue_item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_ok;
    logic       pop_ok;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push_ok    = push && push_ready;
    assign pop_ok     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        count_next  = count_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CRM_ASSERT_NOW(a_occupancy, 1'b1, count_reg <= 2'd2, "queue over capacity")
    `CRM_ASSERT_NEXT(a_fill, push_ok && !pop_ok, count_reg == $past(count_reg) + 2'd1, "fill lost")
    `CRM_ASSERT_NEXT(a_drain, pop_ok && !push_ok, count_reg == $past(count_reg) - 2'd1, "drain lost")

endmodule

// ----- rtl/crm_back.sv -----
// Back end: stick scaling, deadzone test and output register
module crm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [6:0]           nun_dz,
    input  logic [6:0]           cl_dz,
    input  logic                 pop_valid,
    output logic                 pop,
    input  crm_pkg::queue_item_t pop_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [14:0]          m_console_buttons,
    output logic [7:0]           m_left_x,
    output logic [7:0]           m_left_y,
    output logic [7:0]           m_right_x,
    output logic [7:0]           m_right_y,
    output logic                 m_activity
);

    logic        m_valid_reg, m_valid_next;
    logic [14:0] btn_reg;
    logic [7:0]  lx_reg, ly_reg, rx_reg, ry_reg;
    logic        act_reg;
    logic [7:0]  lx, ly, rx, ry;
    logic [7:0]  cx, cy;
    logic        moved;

    assign pop = pop_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        lx    = crm_pkg::STICK_CTR;
        ly    = crm_pkg::STICK_CTR;
        rx    = crm_pkg::STICK_CTR;
        ry    = crm_pkg::STICK_CTR;
        moved = 1'b0;
        cx    = (pop_item.stick_a < crm_pkg::NUN_MIN) ? crm_pkg::NUN_MIN :
                (pop_item.stick_a > crm_pkg::NUN_MAX) ? crm_pkg::NUN_MAX : pop_item.stick_a;
        cy    = (pop_item.stick_b < crm_pkg::NUN_MIN) ? crm_pkg::NUN_MIN :
                (pop_item.stick_b > crm_pkg::NUN_MAX) ? crm_pkg::NUN_MAX : pop_item.stick_b;
        case (pop_item.mode)
            crm_pkg::MODE_NUNCHUK: begin
                lx    = crm_pkg::scale_nunchuk(cx - crm_pkg::NUN_MIN);
                ly    = crm_pkg::scale_nunchuk(crm_pkg::NUN_MAX - cy);
                moved = crm_pkg::beyond(lx, nun_dz) || crm_pkg::beyond(ly, nun_dz);
            end
            crm_pkg::MODE_CLASSIC: begin
                lx    = crm_pkg::scale_six(pop_item.stick_a[5:0]);
                ly    = crm_pkg::STICK_FULL - crm_pkg::scale_six(pop_item.stick_b[5:0]);
                rx    = crm_pkg::scale_five(pop_item.stick_c[4:0]);
                ry    = crm_pkg::scale_five(pop_item.stick_d[4:0]);
                moved = crm_pkg::beyond(lx, cl_dz) || crm_pkg::beyond(ly, cl_dz) ||
                        crm_pkg::beyond(rx, cl_dz) || crm_pkg::beyond(ry, cl_dz);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            btn_reg <= pop_item.buttons;
            lx_reg  <= lx;
            ly_reg  <= ly;
            rx_reg  <= rx;
            ry_reg  <= ry;
            act_reg <= (|pop_item.buttons) || moved;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_console_buttons = btn_reg;
    assign m_left_x          = lx_reg;
    assign m_left_y          = ly_reg;
    assign m_right_x         = rx_reg;
    assign m_right_y         = ry_reg;
    assign m_activity        = act_reg;

endmodule

// ----- rtl/controller_report_mapper_unit.sv -----
// Controller report mapper top level: config registers, front, queue, back
// A report accepted by the front end is written into the queue and then moved
// into the output register when the back end pops it. Throughput: one report
// per cycle while the queue has room; the two-entry queue and output register
// let front and back stall apart. Nunchuk scaling is one reciprocal multiply.
// Reset (aresetn, synchronous): mode none, deadzones 5 and 3, held extension
// state to centre and released; no clearing pass, ready in the next cycle.
module controller_report_mapper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_extension,
    input  logic [15:0] s_core_buttons,
    input  logic [7:0]  s_ext_byte_a,
    input  logic [7:0]  s_ext_byte_b,
    input  logic [7:0]  s_ext_byte_c,
    input  logic [7:0]  s_ext_byte_d,
    input  logic [7:0]  s_ext_byte_e,
    input  logic [7:0]  s_ext_byte_f,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_console_buttons,
    output logic [7:0]  m_left_x,
    output logic [7:0]  m_left_y,
    output logic [7:0]  m_right_x,
    output logic [7:0]  m_right_y,
    output logic        m_activity
);

    crm_pkg::ext_mode_t   mode_reg;
    logic [6:0]           nun_dz_reg;
    logic [6:0]           cl_dz_reg;
    logic                 cfg_wr;
    crm_pkg::front_ctl_t  ctl;
    logic                 push;
    logic                 push_ready;
    crm_pkg::queue_item_t push_item;
    logic                 pop_valid;
    logic                 pop;
    crm_pkg::queue_item_t pop_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign ctl.mode  = mode_reg;
    assign ctl.clear = cfg_wr && (cfg_index == crm_pkg::REG_EXT_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= crm_pkg::MODE_NONE;
            nun_dz_reg <= crm_pkg::NUN_DZ_RESET;
            cl_dz_reg  <= crm_pkg::CL_DZ_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                crm_pkg::REG_EXT_MODE: mode_reg   <= crm_pkg::ext_mode_t'(cfg_data[1:0]);
                crm_pkg::REG_NUN_DZ:   nun_dz_reg <= cfg_data;
                crm_pkg::REG_CL_DZ:    cl_dz_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    crm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_has_extension (s_has_extension),
        .s_core_buttons  (s_core_buttons),
        .s_ext_byte_a    (s_ext_byte_a),
        .s_ext_byte_b    (s_ext_byte_b),
        .s_ext_byte_c    (s_ext_byte_c),
        .s_ext_byte_d    (s_ext_byte_d),
        .s_ext_byte_e    (s_ext_byte_e),
        .s_ext_byte_f    (s_ext_byte_f),
        .push            (push),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    crm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    crm_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .nun_dz            (nun_dz_reg),
        .cl_dz             (cl_dz_reg),
        .pop_valid         (pop_valid),
        .pop               (pop),
        .pop_item          (pop_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_console_buttons (m_console_buttons),
        .m_left_x          (m_left_x),
        .m_left_y          (m_left_y),
        .m_right_x         (m_right_x),
        .m_right_y         (m_right_y),
        .m_activity        (m_activity)
    );

endmodule
